[sv/http_chunked_body_decoder_core_macros.svh]
// Assertion macros for the checker file of the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Checked on every rising edge once reset is released.
`define HCBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

[sv/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and character constants of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef struct packed {
    logic       restart;
    logic       conn_closed;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_BAD,
    PH_DATA,
    PH_SKIP,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       digit_seen;
    logic       trail_space_seen;
    logic       prev_was_cr;
    logic [1:0] skip_left;
  } ctl_state_t;

  localparam ctl_state_t CTL_RESET = '{phase: PH_SIZE, default: '0};

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_BAD_SIZE     = 2'd1;
  localparam logic [1:0] ERR_CLOSED_LINE  = 2'd2;
  localparam logic [1:0] ERR_CLOSED_CHUNK = 2'd3;

  localparam logic [1:0]  SKIP_BYTES     = 2'd2;
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

[sv/hcbd_step.sv]
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic for one raw body byte.
// ----------------------------------------------------------------------------
module hcbd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  hcbd_pkg::in_item_t   item_i,
  input  hcbd_pkg::ctl_state_t ctl_i,
  input  logic [SIZE_BITS-1:0] size_accum_i,
  input  logic [SIZE_BITS-1:0] chunk_left_i,
  input  logic [31:0]          body_count_i,
  input  logic [31:0]          max_body_i,
  output hcbd_pkg::ctl_state_t ctl_o,
  output logic [SIZE_BITS-1:0] size_accum_o,
  output logic [SIZE_BITS-1:0] chunk_left_o,
  output logic [31:0]          body_count_o,
  output logic                 has_result_o,
  output hcbd_pkg::out_item_t  result_o
);
  import hcbd_pkg::*;

  ctl_state_t           ctl;
  logic [SIZE_BITS-1:0] acc;
  logic [SIZE_BITS-1:0] left;
  logic [31:0]          body;
  logic [7:0]           b;
  logic [4:0]           nib;
  logic                 overflow;

  assign b = item_i.data_byte;

  always_comb begin
    ctl          = ctl_i;
    acc          = size_accum_i;
    left         = chunk_left_i;
    body         = body_count_i;
    has_result_o = 1'b0;
    result_o     = '0;
    nib          = hex_nibble(b);

    if (item_i.restart) begin
      ctl  = CTL_RESET;
      acc  = '0;
      left = '0;
      body = '0;
    end
    overflow = (acc[SIZE_BITS-1 -: 4] != 4'd0);

    priority if (ctl.phase == PH_DONE || ctl.phase == PH_ERR) begin
      // sticky until restart
    end else if (item_i.conn_closed) begin
      has_result_o    = 1'b1;
      result_o.kind   = KIND_ERROR;
      result_o.error_code =
        (ctl.phase == PH_DATA || ctl.phase == PH_SKIP) ? ERR_CLOSED_CHUNK : ERR_CLOSED_LINE;
      ctl.phase = PH_ERR;
    end else if (ctl.phase == PH_DATA) begin
      if (body < max_body_i) begin
        body                  = body + 32'd1;
        has_result_o          = 1'b1;
        result_o.kind         = KIND_PAYLOAD;
        result_o.payload_byte = b;
      end
      left = left - SIZE_BITS'(1);
      if (left == '0) begin
        ctl.phase     = PH_SKIP;
        ctl.skip_left = SKIP_BYTES;
      end
    end else if (ctl.phase == PH_SKIP) begin
      ctl.skip_left = ctl.skip_left - 2'd1;
      if (ctl.skip_left == 2'd0) begin
        if (body >= max_body_i) begin
          ctl.phase     = PH_DONE;
          has_result_o  = 1'b1;
          result_o.kind = KIND_COMPLETE;
        end else begin
          ctl = CTL_RESET;
          acc = '0;
        end
      end
    end else if (ctl.prev_was_cr && b == CH_LF) begin
      // end of size line
      ctl.prev_was_cr = 1'b0;
      if (ctl.phase == PH_BAD || !ctl.digit_seen) begin
        ctl.phase           = PH_ERR;
        has_result_o        = 1'b1;
        result_o.kind       = KIND_ERROR;
        result_o.error_code = ERR_BAD_SIZE;
      end else if (acc == '0) begin
        ctl.phase     = PH_DONE;
        has_result_o  = 1'b1;
        result_o.kind = KIND_COMPLETE;
      end else begin
        left      = acc;
        ctl.phase = PH_DATA;
      end
    end else begin
      // a CR not followed by LF is whitespace of the line
      if (ctl.prev_was_cr) begin
        ctl.prev_was_cr = 1'b0;
        if (ctl.phase == PH_SIZE && ctl.digit_seen) begin
          ctl.trail_space_seen = 1'b1;
        end
      end
      if (b == CH_CR) begin
        ctl.prev_was_cr = 1'b1;
      end else if (ctl.phase == PH_SIZE) begin
        priority if (b == CH_SEMI) begin
          ctl.phase = PH_EXT;
        end else if (is_space(b)) begin
          ctl.trail_space_seen = ctl.trail_space_seen | ctl.digit_seen;
        end else if (!nib[4] || ctl.trail_space_seen || overflow) begin
          ctl.phase = PH_BAD;
        end else begin
          acc            = {acc[SIZE_BITS-5:0], nib[3:0]};
          ctl.digit_seen = 1'b1;
        end
      end
    end

    ctl_o        = ctl;
    size_accum_o = acc;
    chunk_left_o = left;
    body_count_o = body;
  end

endmodule

[sv/http_chunked_body_decoder_core.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// De-chunks an HTTP/1.1 chunked response body, one raw byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one raw body byte per
// transaction, with restart (clear decoder state first) and conn_closed.
// Output channel (out_valid_o / out_stall_i / out_data_o): zero or one result
// per input byte: a payload byte, body complete, or an error code.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): max_body_bytes,
// always ready; write it only while the decoder is idle.
// Throughput is one byte per cycle while the result register is not stalled:
// the per-byte update is a single pass of logic between the input register
// and the result register, with the size accumulator, chunk counter and body
// counter updated in that same cycle; each byte passes both registers in turn.
// While the result register is stalled the input register holds one more
// byte; the input side stalls only when both are full.
// Reset clears the decoder to the start of a size line and the cap to
// 1048576. After completion or an error bytes are dropped until restart.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcbd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hcbd_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i
);
  import hcbd_pkg::*;

  logic                 s1_valid_q;
  logic                 s1_valid_d;
  in_item_t             s1_item_q;
  logic                 out_valid_q;
  logic                 out_valid_d;
  out_item_t            out_item_q;
  logic [31:0]          max_body_q;

  ctl_state_t           ctl_q, ctl_d;
  logic [SIZE_BITS-1:0] size_accum_q, size_accum_d;
  logic [SIZE_BITS-1:0] chunk_left_q, chunk_left_d;
  logic [31:0]          body_count_q, body_count_d;
  logic                 has_result;
  out_item_t            result;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_take || (s1_valid_q && !advance);
  assign out_valid_d = advance ? has_result : (out_valid_q && out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .item_i      (s1_item_q),
    .ctl_i       (ctl_q),
    .size_accum_i(size_accum_q),
    .chunk_left_i(chunk_left_q),
    .body_count_i(body_count_q),
    .max_body_i  (max_body_q),
    .ctl_o       (ctl_d),
    .size_accum_o(size_accum_d),
    .chunk_left_o(chunk_left_d),
    .body_count_o(body_count_d),
    .has_result_o(has_result),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      max_body_q   <= MAX_BODY_RESET;
      ctl_q        <= CTL_RESET;
      size_accum_q <= '0;
      chunk_left_q <= '0;
      body_count_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_body_q <= cfg_data_i;
      end
      if (advance) begin
        ctl_q        <= ctl_d;
        size_accum_q <= size_accum_d;
        chunk_left_q <= chunk_left_d;
        body_count_q <= body_count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_data_i;
    end
    if (advance && has_result) begin
      out_item_q <= result;
    end
  end

endmodule

[sv/hcbd_checker.sv]
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hcbd_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);
  import hcbd_pkg::*;

  logic err_clean;
  logic byte_clean;

  // fields not belonging to the result kind read as zero
  assign err_clean  = (out_data_o.kind == KIND_ERROR) || (out_data_o.error_code == ERR_NONE);
  assign byte_clean = (out_data_o.kind == KIND_PAYLOAD) || (out_data_o.payload_byte == 8'd0);

  // a stalled result stays offered
  `HCBD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // input side only backs up behind a stalled result
  `HCBD_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

  `HCBD_ASSERT(a_clean_fields, out_valid_o |-> (err_clean && byte_clean))

  // config port never back-pressures
  `HCBD_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_ready_o(cfg_ready_o)
);

[tb/sv/tb_http_chunked_body_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core
// Self-checking bench for the chunked body decoder. Directed bodies cover
// well-formed chunks, size-line errors, connection close and the body cap
// extremes; a backpressure pass fills the decoder; then random well-formed,
// broken and noisy bodies run under random idling and cap settings. Every
// result is compared with a transaction-level model of the decoder.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_core;
  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_IDLE      = 6;
  localparam int unsigned RANDOM_BYTES  = 1700;
  localparam string       CRLF          = "\015\012";

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  // decoder model state
  phase_e      ph;
  logic [31:0] size_acc;
  logic        have_digit;
  logic        ws_after_digit;
  logic        pending_cr;
  logic [31:0] left_in_chunk;
  logic [31:0] kept_bytes;
  logic [1:0]  trail_left;
  logic [31:0] cap_bytes;

  out_item_t   decoded_q[$];
  int unsigned fed_bytes   = 0;
  int unsigned failed      = 0;
  int unsigned sink_hold   = 0;
  logic        send_idle   = 1'b1;
  logic        sink_idle   = 1'b1;
  logic        restart_due = 1'b0;
  string       noise_chars = "0123456789abcdefABCDEFgGxz; \t\015\012";

  http_chunked_body_decoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic void new_line();
    ph             = PH_SIZE;
    size_acc       = '0;
    have_digit     = 1'b0;
    ws_after_digit = 1'b0;
    pending_cr     = 1'b0;
  endfunction

  function automatic void clear_body();
    new_line();
    left_in_chunk = '0;
    kept_bytes    = '0;
    trail_left    = '0;
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [7:0] b,
                                      input logic [1:0] code);
    out_item_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.error_code   = code;
    decoded_q.push_back(r);
  endfunction

  function automatic void size_char(input logic [7:0] c);
    int v;
    if (ph != PH_SIZE) return;
    if (c == CH_SEMI) begin
      ph = PH_EXT;
      return;
    end
    if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      if (have_digit) ws_after_digit = 1'b1;
      return;
    end
    v = hex_val(c);
    // overflow is caught before the shift, the line goes bad
    if (v < 0 || ws_after_digit || size_acc[31:28] != 4'd0) begin
      ph = PH_BAD;
      return;
    end
    size_acc   = {size_acc[27:0], v[3:0]};
    have_digit = 1'b1;
  endfunction

  // Returns 1 unless the byte is dropped after completion or an error.
  function automatic bit decode_byte(input in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (it.restart) clear_body();
    if (ph == PH_DONE || ph == PH_ERR) return 1'b0;
    if (it.conn_closed) begin
      push_result(KIND_ERROR, 8'h00,
                  (ph == PH_DATA || ph == PH_SKIP) ? ERR_CLOSED_CHUNK : ERR_CLOSED_LINE);
      ph = PH_ERR;
      return 1'b1;
    end
    if (ph == PH_DATA) begin
      if (kept_bytes < cap_bytes) begin
        kept_bytes++;
        push_result(KIND_PAYLOAD, b, ERR_NONE);
      end
      left_in_chunk--;
      if (left_in_chunk == 0) begin
        ph         = PH_SKIP;
        trail_left = SKIP_BYTES;
      end
      return 1'b1;
    end
    if (ph == PH_SKIP) begin
      trail_left--;
      if (trail_left != 0) return 1'b1;
      if (kept_bytes >= cap_bytes) begin
        ph = PH_DONE;
        push_result(KIND_COMPLETE, 8'h00, ERR_NONE);
      end else begin
        new_line();
      end
      return 1'b1;
    end
    if (pending_cr) begin
      pending_cr = 1'b0;
      if (b == CH_LF) begin
        if (ph == PH_BAD || !have_digit) begin
          ph = PH_ERR;
          push_result(KIND_ERROR, 8'h00, ERR_BAD_SIZE);
        end else if (size_acc == 0) begin
          ph = PH_DONE;
          push_result(KIND_COMPLETE, 8'h00, ERR_NONE);
        end else begin
          left_in_chunk = size_acc;
          ph            = PH_DATA;
        end
        return 1'b1;
      end
      // lone CR is whitespace
      size_char(CH_CR);
    end
    if (b == CH_CR) pending_cr = 1'b1;
    else size_char(b);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // --------------------------------------------------------------------------
  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: kind %0d, payload_byte %02h, error_code %0d",
             got.kind, got.payload_byte, got.error_code);
      failed++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      failed++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %02h, actual %02h", want.payload_byte, got.payload_byte);
      failed++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
      failed++;
    end
  endfunction

  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        wait_left = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      @(negedge clk_i);
      if (sink_hold != 0) begin
        out_stall_i <= 1'b1;
        sink_hold--;
      end else if (wait_left != 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[http_chunked_body_decoder_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(it)) fed_bytes++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic closed = 1'b0,
                           input logic rst = 1'b0);
    in_item_t it;
    it.restart     = restart_due | rst;
    it.conn_closed = closed;
    it.data_byte   = b;
    restart_due    = 1'b0;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_data(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic begin_body();
    restart_due = 1'b1;
  endtask

  // waits until every expected result is in and the pipeline has gone quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_bytes = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // well-formed size line with random padding, case, zeros and extension
  function automatic string size_line(input int unsigned n);
    string s;
    s = $sformatf("%0h", n);
    if ($urandom_range(0, 3) == 0) s = s.toupper();
    if ($urandom_range(0, 4) == 0) s = {"00", s};
    if ($urandom_range(0, 5) == 0) s = {" \t\012", s};
    if ($urandom_range(0, 5) == 0) s = {s, "\015 "};
    if ($urandom_range(0, 4) == 0) s = {s, " \t"};
    if ($urandom_range(0, 4) == 0) s = {s, ";name=v\015x"};
    return {s, CRLF};
  endfunction

  function automatic logic [31:0] random_cap();
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return MAX_BODY_RESET;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  task automatic good_chunk(input int unsigned n);
    send_text(size_line(n));
    send_data(n);
    // trailing pair is not checked by the decoder
    if ($urandom_range(0, 3) == 0) send_data(2);
    else send_text(CRLF);
  endtask

  task automatic random_body();
    int unsigned n;
    begin_body();
    repeat ($urandom_range(0, 4)) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      good_chunk(n);
    end
    send_text(size_line(0));
    if ($urandom_range(0, 3) == 0) send_text(CRLF);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)),
                                          $urandom_range(0, 31) == 0,
                                          $urandom_range(0, 15) == 0);
      else send_byte(noise_chars[$urandom_range(0, noise_chars.len() - 1)],
                     $urandom_range(0, 31) == 0, $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic broken_body();
    int unsigned n;
    begin_body();
    if ($urandom_range(0, 1)) good_chunk($urandom_range(1, 12));
    case ($urandom_range(0, 7))
      0: send_text({$sformatf("%0h", $urandom_range(1, 255)), "g", CRLF});
      1: send_text({$sformatf("%0h", $urandom_range(1, 15)), " ",
                    $sformatf("%0h", $urandom_range(0, 15)), CRLF});
      2: send_text({" \t;ext", CRLF});
      // nine significant digits overflow 32 bits
      3: send_text({$sformatf("%0h", $urandom_range(1, 15)), $sformatf("%08h", $urandom), CRLF});
      4: begin
        if ($urandom_range(0, 1)) send_text($sformatf("%0h", $urandom_range(1, 255)));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      5: begin
        n = $urandom_range(1, 12);
        send_text(size_line(n));
        send_data($urandom_range(0, n - 1));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      6: begin
        n = $urandom_range(1, 12);
        send_text(size_line(n));
        send_data(n + $urandom_range(0, 1));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_noise($urandom_range(5, 30));
    endcase
    if ($urandom_range(0, 2) == 0) send_text({"0", CRLF});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_basic_body();
    begin_body();
    send_text({"2\015 ", CRLF});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text(CRLF);
    send_text({"0", CRLF});
    send_text("Z");
  endtask

  task automatic test_size_line_errors();
    begin_body();
    send_text({"100000000", CRLF});
    begin_body();
    send_text({"g", CRLF});
    send_text("1");
  endtask

  task automatic test_connection_close();
    begin_body();
    send_byte("1");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    begin_body();
    send_text({"1", CRLF});
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_body_cap();
    write_cap(32'h0000_0000);
    begin_body();
    send_text({"1", CRLF, "Q", CRLF});
    write_cap(32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    sink_idle = 1'b0;
    begin_body();
    send_text({"28", CRLF});
    sink_hold = 150;
    send_data(40);
    send_text({CRLF, "10", CRLF});
    send_data(8);
    // sender waits mid-chunk for every outstanding result
    drain();
    send_data(8);
    send_text({CRLF, "0", CRLF});
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_random_bodies();
    int unsigned goal;
    goal = fed_bytes + RANDOM_BYTES;
    while (fed_bytes < goal) begin
      if ($urandom_range(0, 9) == 0) write_cap(random_cap());
      if ($urandom_range(0, 7) == 0) begin
        send_idle = 1'($urandom_range(0, 1));
        sink_idle = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) == 0) broken_body();
      else random_body();
    end
  endtask

  initial begin : main_seq
    cap_bytes = MAX_BODY_RESET;
    clear_body();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_body();
    test_size_line_errors();
    test_connection_close();
    test_body_cap();
    test_backpressure();
    test_random_bodies();

    drain();
    if (failed == 0) begin
      $display("[http_chunked_body_decoder_core] OK");
    end else begin
      $display("[http_chunked_body_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
